[rtl/c2p_pkg.sv]
`timescale 1ns / 1ps

package c2p_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned ColourW  = 4;
  localparam int unsigned Planes   = 4;
  localparam int unsigned PlaneW   = 8;
  localparam int unsigned TileRows = 8;
  localparam int unsigned TileCols = 8;
  localparam int unsigned WordW    = Planes * PlaneW;
  localparam int unsigned RowW     = $clog2(TileRows);
  localparam int unsigned ColW     = $clog2(TileCols);
  localparam int unsigned CntW     = RowW + ColW;
  localparam int unsigned IdxW     = 5;

  typedef logic [PixW-1:0]    pix_t;
  typedef logic [ColourW-1:0] colour_t;
  typedef logic [PlaneW-1:0]  byte_t;
  typedef logic [WordW-1:0]   word_t;
  typedef logic [RowW-1:0]    row_t;
  typedef logic [ColW-1:0]    col_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [IdxW-1:0]    idx_t;

  typedef struct packed {
    logic  en;
    row_t  addr;
    word_t data;
  } ram_wr_t;

endpackage

[rtl/c2p_if.sv]
`timescale 1ns / 1ps

interface c2p_pix_if;
  import c2p_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface c2p_tile_if;
  import c2p_pkg::*;

  logic  valid;
  logic  ready;
  byte_t tile_byte;
  idx_t  byte_index;
  logic  last;

  modport source (output valid, output tile_byte, output byte_index, output last, input ready);
  modport sink (input valid, input tile_byte, input byte_index, input last, output ready);
endinterface

[rtl/chunky_to_planar_4bpp_tile.sv]
`timescale 1ns / 1ps
// Pixel side: one transaction per cycle while a tile fills (64 transactions).
// The 64th pixel stalls the input; after the ST_READ state, the first tile byte is
// valid in ST_SHOW and the 32 bytes then follow at one per cycle while the sink is
// ready. Reset clears the counters and state; the row store is left as is, since
// every bit is rewritten in each tile.

module chunky_to_planar_4bpp_tile (
  input logic         clk_i,
  input logic         rst_ni,
  c2p_pix_if.sink     pix_i,
  c2p_tile_if.source  tile_o
);
  import c2p_pkg::*;

  typedef enum logic [2:0] {
    ST_FILL = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_e;

  state_e  state_q, state_d;
  cnt_t    cnt_q, cnt_d;
  idx_t    k_q, k_d;
  idx_t    k_next;
  logic    pix_acc;
  logic    tile_acc;
  logic    k_last;
  logic    rd_en;
  row_t    rd_addr;
  word_t   rd_data;
  ram_wr_t wr;
  logic [1:0] plane;

  assign pix_i.ready = (state_q == ST_FILL);
  assign pix_acc     = pix_i.valid & pix_i.ready;
  assign tile_acc    = tile_o.valid & tile_o.ready;
  assign k_last      = (k_q == idx_t'(31));
  assign k_next      = k_q + idx_t'(1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    rd_en   = 1'b0;
    rd_addr = cnt_q[CntW-1:ColW];
    case (state_q)
      ST_FILL: begin
        rd_en = pix_acc;
        if (pix_acc) begin
          cnt_d = cnt_q + cnt_t'(1);
          if (cnt_q == '1) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = k_q[3:1];
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        rd_addr = k_next[3:1];
        if (tile_acc) begin
          k_d   = k_next;
          rd_en = !k_last;
          if (k_last) begin
            state_d = ST_FILL;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  c2p_rmw u_rmw (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (pix_acc),
    .cnt_i     (cnt_q),
    .colour_i  (pix_i.pixel[ColourW-1:0]),
    .rd_data_i (rd_data),
    .wr_o      (wr)
  );

  c2p_ram #(
    .DataW (WordW),
    .Depth (TileRows)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign plane             = {k_q[4], k_q[0]};
  assign tile_o.valid      = (state_q == ST_SHOW);
  assign tile_o.tile_byte  = rd_data[{plane, 3'b000} +: PlaneW];
  assign tile_o.byte_index = k_q;
  assign tile_o.last       = k_last;

endmodule

[rtl/c2p_ram.sv]
`timescale 1ns / 1ps

module c2p_ram #(
  parameter int unsigned DataW = 32,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/c2p_rmw.sv]
`timescale 1ns / 1ps

module c2p_rmw (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  c2p_pkg::cnt_t     cnt_i,
  input  c2p_pkg::colour_t  colour_i,
  input  c2p_pkg::word_t    rd_data_i,
  output c2p_pkg::ram_wr_t  wr_o
);
  import c2p_pkg::*;

  logic    vld_q, vld_d;
  row_t    row_q;
  col_t    col_q;
  colour_t colour_q;
  logic    fvld_q, fvld_d;
  row_t    frow_q;
  word_t   fword_q;
  word_t   base;
  word_t   merged;

  assign vld_d  = acc_i;
  assign fvld_d = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      fvld_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      fvld_q <= fvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      row_q    <= cnt_i[CntW-1:ColW];
      col_q    <= cnt_i[ColW-1:0];
      colour_q <= colour_i;
    end
    frow_q  <= row_q;
    fword_q <= merged;
  end

  // forward the previous write, whose entry the RAM read missed
  assign base = (fvld_q && (frow_q == row_q)) ? fword_q : rd_data_i;

  always_comb begin
    merged = base;
    for (int p = 0; p < Planes; p++) begin
      merged[{p[1:0], ~col_q}] = colour_q[p];
    end
  end

  assign wr_o = '{en: vld_q, addr: row_q, data: merged};

endmodule

[sim/tb_chunky_to_planar_4bpp_tile.sv]
`timescale 1ns / 1ps

module tb_chunky_to_planar_4bpp_tile;
  import c2p_pkg::*;

  typedef struct packed {
    byte_t data;
    idx_t  index;
    logic  last;
  } planar_byte_t;

  class tile_scoreboard;
    byte_t        planes[32];
    logic [5:0]   pixel_pos;
    planar_byte_t tile_bytes[$];
    int unsigned  errors;
    int unsigned  pixels_seen;
    int unsigned  bytes_seen;

    function new();
      foreach (planes[i]) planes[i] = '0;
      pixel_pos   = '0;
      errors      = 0;
      pixels_seen = 0;
      bytes_seen  = 0;
    endfunction

    function void note_pixel(pix_t p);
      colour_t      colour;
      int unsigned  row;
      int unsigned  bit_pos;
      planar_byte_t b;
      colour  = p[ColourW-1:0];
      row     = int'(pixel_pos[5:3]);
      bit_pos = 7 - pixel_pos[2:0];
      planes[row*2][bit_pos]      = colour[0];
      planes[row*2 + 1][bit_pos]  = colour[1];
      planes[16 + row*2][bit_pos] = colour[2];
      planes[17 + row*2][bit_pos] = colour[3];
      pixels_seen++;
      if (pixel_pos == 6'd63) begin
        for (int k = 0; k < 32; k++) begin
          b.data  = planes[k];
          b.index = idx_t'(k);
          b.last  = (k == 31);
          tile_bytes.push_back(b);
        end
      end
      pixel_pos = pixel_pos + 6'd1;
    endfunction

    function void check_byte(byte_t data, idx_t index, logic last);
      planar_byte_t want;
      bytes_seen++;
      if (tile_bytes.size() == 0) begin
        $display("%0t: unexpected tile byte data=%h index=%0d last=%b",
                 $time, data, index, last);
        errors++;
        return;
      end
      want = tile_bytes.pop_front();
      if (data !== want.data) begin
        $display("%0t: tile_byte expected %h actual %h (index %0d)",
                 $time, want.data, data, want.index);
        errors++;
      end
      if (index !== want.index) begin
        $display("%0t: byte_index expected %0d actual %0d", $time, want.index, index);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b actual %b (index %0d)",
                 $time, want.last, last, want.index);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return tile_bytes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   sink_hold;

  c2p_pix_if  pix ();
  c2p_tile_if tile ();

  chunky_to_planar_4bpp_tile dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .tile_o (tile)
  );

  tile_scoreboard sb = new();

  pix_t seed_pixels[24] = '{
    8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h01, 8'h02, 8'h04, 8'h08,
    8'h10, 8'h20, 8'h40, 8'h80, 8'h0E, 8'h0D, 8'h0B, 8'h07,
    8'hA5, 8'h5A, 8'hFE, 8'h7F, 8'h0F, 8'h00, 8'h0F, 8'hF5
  };

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pix_t tile_pixel(int style);
    logic [3:0]  hi;
    logic [3:0]  lo;
    int unsigned r;
    hi = 4'($urandom_range(0, 15));
    lo = 4'($urandom_range(0, 15));
    r  = $urandom_range(0, 9);
    case (style)
      1: if (r < 6) lo = 4'hF;
      2: if (r < 6) lo = 4'h0;
      default: ;
    endcase
    return {hi, lo};
  endfunction

  task automatic send_pixel(input pix_t p, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      pix.valid = 1'b0;
      pix.pixel = pix_t'($urandom_range(0, 255));
    end
    @(negedge clk_i);
    pix.valid = 1'b1;
    pix.pixel = p;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold = sink_hold - 1;
    end else if (steady || $urandom_range(0, 2) != 0) begin
      tile.ready = 1'b1;
      sink_hold  = $urandom_range(0, 6);
    end else begin
      tile.ready = 1'b0;
      sink_hold  = gap_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix.valid && pix.ready) sb.note_pixel(pix.pixel);
      if (tile.valid && tile.ready) sb.check_byte(tile.tile_byte, tile.byte_index, tile.last);
    end
  end

  initial begin
    pix.valid  = 1'b0;
    pix.pixel  = '0;
    tile.ready = 1'b0;
    rst_ni     = 1'b0;
    steady     = 1'b0;
    sink_hold  = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (seed_pixels[i]) send_pixel(seed_pixels[i], gap_len());

    for (int n = 24; n < 192; n++) begin
      steady = ((n >> 6) == 1);
      send_pixel(tile_pixel(n >> 6), steady ? 0 : gap_len());
    end
    steady = 1'b0;
    @(negedge clk_i);
    pix.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Converted %0d pixels into %0d tiles; %0d planar bytes compared.",
             sb.pixels_seen, sb.pixels_seen / 64, sb.bytes_seen);
    $display("Covered extreme and single-bit pixels, set-heavy and clear-heavy tiles, both-side stalls.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[chunky_to_planar_4bpp_tile.f]
rtl/c2p_pkg.sv
rtl/c2p_if.sv
rtl/c2p_ram.sv
rtl/c2p_rmw.sv
rtl/chunky_to_planar_4bpp_tile.sv
sim/tb_chunky_to_planar_4bpp_tile.sv
